// ===== hdl/host_address_classifier_macros.svh =====
// Assertion macros shared by the checker of the host address classifier.
`ifndef HOST_ADDRESS_CLASSIFIER_MACROS_SVH
`define HOST_ADDRESS_CLASSIFIER_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define HAC_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("host address classifier: invariant violated");

// An implication checked in the same cycle.
`define HAC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("host address classifier: implication violated");

// An implication whose consequent is checked in the cycle after its antecedent.
`define HAC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("host address classifier: sequence violated");

`endif

// ===== hdl/hac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hac_pkg
// Types, constants and helper functions of the host address classifier.
// ----------------------------------------------------------------------------
package hac_pkg;

    localparam int MAX_HOST_LEN = 256;
    localparam int POS_W        = $clog2(MAX_HOST_LEN + 1);
    localparam int LEN_W        = POS_W + 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int DEPTH_W      = 9;
    localparam int LABEL_W      = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALLOW_LOCALHOST    = 2'd0,
        CFG_ALLOW_PRIVATE_IPS  = 2'd1,
        CFG_ALLOW_IP_ADDRESSES = 2'd2,
        CFG_MAX_LABEL_DEPTH    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        VERD_PASS       = 3'd0,
        VERD_LOOPBACK   = 3'd1,
        VERD_PRIVATE_V4 = 3'd2,
        VERD_LINK_LOCAL = 3'd3,
        VERD_PRIVATE_V6 = 3'd4,
        VERD_IP_BLOCKED = 3'd5
    } verdict_t;

    typedef enum logic [2:0] {
        WARN_NONE       = 3'd0,
        WARN_LOOPBACK   = 3'd1,
        WARN_PRIVATE    = 3'd2,
        WARN_LINK_LOCAL = 3'd3,
        WARN_PRIVATE_V6 = 3'd4,
        WARN_LITERAL_IP = 3'd5,
        WARN_DEEP       = 3'd6
    } warning_t;

    typedef enum logic [1:0] {
        NAME_LOCAL_ID    = 2'd0,
        NAME_LOCALDOM_ID = 2'd1,
        NAME_V6SHORT_ID  = 2'd2,
        NAME_V6LONG_ID   = 2'd3
    } name_id_t;

    localparam int NAME_COUNT   = 4;
    localparam int LEN_LOCAL    = 9;
    localparam int LEN_LOCALDOM = 21;
    localparam int LEN_V6SHORT  = 3;
    localparam int LEN_V6LONG   = 15;

    localparam logic [8*LEN_LOCAL-1:0]    NAME_LOCAL    = "localhost";
    localparam logic [8*LEN_LOCALDOM-1:0] NAME_LOCALDOM = "localhost.localdomain";
    localparam logic [8*LEN_V6SHORT-1:0]  NAME_V6SHORT  = "::1";
    localparam logic [8*LEN_V6LONG-1:0]   NAME_V6LONG   = "0:0:0:0:0:0:0:1";

    localparam logic [7:0] CH_DOT      = ".";
    localparam logic [7:0] CH_COLON    = ":";
    localparam logic [7:0] CH_LBRACKET = "[";
    localparam logic [7:0] CH_RBRACKET = "]";
    localparam logic [7:0] CH_ZERO     = "0";
    localparam logic [7:0] CH_NINE     = "9";
    localparam logic [7:0] CH_UPPER_A  = "A";
    localparam logic [7:0] CH_UPPER_Z  = "Z";
    localparam logic [7:0] CH_A        = "a";
    localparam logic [7:0] CH_B        = "b";
    localparam logic [7:0] CH_C        = "c";
    localparam logic [7:0] CH_D        = "d";
    localparam logic [7:0] CH_E        = "e";
    localparam logic [7:0] CH_F        = "f";
    localparam logic [7:0] CH_EIGHT    = "8";

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             bracket;
        logic [1:0]       oct_idx;
        logic [9:0]       oct_val;
        logic [1:0]       digits;
        logic             v4_fail;
        logic [7:0]       first;
        logic [7:0]       second;
        logic             nonzero;
        logic [7:0]       dots;
        logic [1:0]       colons;
        logic [NAME_COUNT-1:0] names;
        logic [2:0][7:0]  prefix;
    } scan_t;

    localparam scan_t SCAN_RESET = '{
        pos:     '0,
        bracket: 1'b0,
        oct_idx: '0,
        oct_val: '0,
        digits:  '0,
        v4_fail: 1'b0,
        first:   '0,
        second:  '0,
        nonzero: 1'b0,
        dots:    '0,
        colons:  '0,
        names:   '1,
        prefix:  '0
    };

    typedef struct packed {
        verdict_t           verdict;
        warning_t           warning;
        logic               is_ip;
        logic               is_loopback;
        logic               is_private_v4;
        logic               is_link_local;
        logic               is_private_v6;
        logic [LABEL_W-1:0] label_count;
    } result_t;

    function automatic logic [4:0] name_len(input name_id_t id);
        logic [4:0] len;
        len = 5'(LEN_LOCAL);
        unique case (id)
            NAME_LOCAL_ID:    len = 5'(LEN_LOCAL);
            NAME_LOCALDOM_ID: len = 5'(LEN_LOCALDOM);
            NAME_V6SHORT_ID:  len = 5'(LEN_V6SHORT);
            NAME_V6LONG_ID:   len = 5'(LEN_V6LONG);
        endcase
        return len;
    endfunction

    // True when byte c stands at position idx of the fixed name.
    function automatic logic name_hit(input name_id_t id, input logic [POS_W-1:0] idx,
                                      input logic [7:0] c);
        logic hit;
        int   p;
        hit = 1'b0;
        p   = int'(idx);
        unique case (id)
            NAME_LOCAL_ID:
                if (p < LEN_LOCAL)
                    hit = (NAME_LOCAL[8*(LEN_LOCAL-1-p) +: 8] == c);
            NAME_LOCALDOM_ID:
                if (p < LEN_LOCALDOM)
                    hit = (NAME_LOCALDOM[8*(LEN_LOCALDOM-1-p) +: 8] == c);
            NAME_V6SHORT_ID:
                if (p < LEN_V6SHORT)
                    hit = (NAME_V6SHORT[8*(LEN_V6SHORT-1-p) +: 8] == c);
            NAME_V6LONG_ID:
                if (p < LEN_V6LONG)
                    hit = (NAME_V6LONG[8*(LEN_V6LONG-1-p) +: 8] == c);
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
    endfunction

endpackage

// ===== hdl/hac_host_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hac_host_if
// Channel carrying host name bytes into the classifier.
// ----------------------------------------------------------------------------
interface hac_host_if;
    logic       valid;
    logic       ready;
    logic [7:0] host_char;
    logic       last;

    modport source (output valid, output host_char, output last, input ready);
    modport sink   (input valid, input host_char, input last, output ready);
endinterface

// ===== hdl/hac_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hac_result_if
// Channel carrying one classification result per host.
// ----------------------------------------------------------------------------
interface hac_result_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    verdict;
    logic [2:0]                    warning;
    logic                          is_ip;
    logic                          is_loopback;
    logic                          is_private_v4;
    logic                          is_link_local;
    logic                          is_private_v6;
    logic [hac_pkg::LABEL_W-1:0]   label_count;

    modport source (output valid, output verdict, output warning, output is_ip,
                    output is_loopback, output is_private_v4, output is_link_local,
                    output is_private_v6, output label_count, input ready);
    modport sink   (input valid, input verdict, input warning, input is_ip,
                    input is_loopback, input is_private_v4, input is_link_local,
                    input is_private_v6, input label_count, output ready);
endinterface

// ===== hdl/hac_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hac_cfg_if
// Register write channel of the classifier.
// ----------------------------------------------------------------------------
interface hac_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hac_pkg::CFG_IDX_W-1:0]    index;
    logic [hac_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/host_address_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_address_classifier
// Scans a URL host one byte per transaction and classifies it as loopback,
// private, link-local, unique-local or literal IP, with a verdict and warning.
// ----------------------------------------------------------------------------
// Channel  Role  Transaction
// host     sink  one host byte with its last flag
// result   source one classification, after each byte marked last
// cfg      sink  one register write (index, data)
//
// One byte is taken every cycle unless a last byte is stalled; a byte is held
// in the input register and its scan update is applied from there.
// A result is written to the result register as its last byte leaves the input
// register and waits there; only a last byte stalls behind an unread result.
// Reset clears the scan state and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module host_address_classifier
(
    input  logic         clk,
    input  logic         rst_n,
    hac_host_if.sink     host,
    hac_result_if.source result,
    hac_cfg_if.sink      cfg
);

    logic                          allow_localhost_reg;
    logic                          allow_private_reg;
    logic                          allow_ip_reg;
    logic [hac_pkg::DEPTH_W-1:0]   max_depth_reg;

    logic                          in_valid_reg;
    logic [7:0]                    in_char_reg;
    logic                          in_last_reg;

    hac_pkg::scan_t                scan_reg;
    hac_pkg::scan_t                scan_next;

    logic                          out_valid_reg;
    hac_pkg::result_t              res_reg;
    hac_pkg::result_t              res_next;

    logic                          advance;
    logic                          host_take;
    logic                          overlong;
    logic                          opening;
    logic                          closing;
    logic [hac_pkg::POS_W-1:0]     idx;
    logic [9:0]                    tenfold;

    logic [hac_pkg::LEN_W-1:0]     n;
    logic [hac_pkg::LEN_W-1:0]     clen;
    logic                          strip_ok;
    logic                          parse_ok;
    logic                          v4_strip;
    logic                          v4_plain;
    logic                          zero_addr;
    logic                          names_hit;
    logic                          loop;
    logic                          priv4;
    logic                          link;
    logic                          priv6;
    logic                          is_ip;
    logic [hac_pkg::LABEL_W-1:0]   labels;

    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || result.ready);
    assign host.ready = !in_valid_reg || advance;
    assign host_take = host.valid && host.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_localhost_reg <= 1'b0;
            allow_private_reg   <= 1'b0;
            allow_ip_reg        <= 1'b0;
            max_depth_reg       <= hac_pkg::DEPTH_W'(5);
        end
        else if (cfg.valid)
        begin
            unique case (hac_pkg::cfg_reg_t'(cfg.index))
                hac_pkg::CFG_ALLOW_LOCALHOST:    allow_localhost_reg <= cfg.data[0];
                hac_pkg::CFG_ALLOW_PRIVATE_IPS:  allow_private_reg   <= cfg.data[0];
                hac_pkg::CFG_ALLOW_IP_ADDRESSES: allow_ip_reg        <= cfg.data[0];
                hac_pkg::CFG_MAX_LABEL_DEPTH:    max_depth_reg       <= cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (host_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (host_take)
        begin
            in_char_reg <= host.host_char;
            in_last_reg <= host.last;
        end
    end

    assign overlong = scan_reg.pos >= hac_pkg::POS_W'(hac_pkg::MAX_HOST_LEN);
    assign idx      = scan_reg.pos - hac_pkg::POS_W'(scan_reg.bracket);
    assign opening  = (scan_reg.pos == '0) && (in_char_reg == hac_pkg::CH_LBRACKET);
    assign closing  = !opening && in_last_reg && scan_reg.bracket &&
                      (in_char_reg == hac_pkg::CH_RBRACKET);
    assign tenfold  = {scan_reg.oct_val[6:0], 3'b000} + {scan_reg.oct_val[8:0], 1'b0};

    always_comb
    begin
        scan_next = scan_reg;

        if (in_char_reg == hac_pkg::CH_DOT && scan_reg.dots != 8'hFF)
        begin
            scan_next.dots = scan_reg.dots + 8'd1;
        end

        if (in_char_reg == hac_pkg::CH_COLON)
        begin
            scan_next.colons = {scan_reg.colons[1] | scan_reg.colons[0], 1'b1};
        end
        else
        begin
            scan_next.colons = {scan_reg.colons[1], 1'b0};
        end

        if (opening)
        begin
            scan_next.bracket = 1'b1;
        end
        else if (!closing)
        begin
            for (int b = 0; b < hac_pkg::NAME_COUNT; b++)
            begin
                if (!hac_pkg::name_hit(hac_pkg::name_id_t'(b), idx, in_char_reg))
                begin
                    scan_next.names[b] = 1'b0;
                end
            end
            if (overlong)
            begin
                scan_next.names   = '0;
                scan_next.v4_fail = 1'b1;
            end
            for (int k = 0; k < 3; k++)
            begin
                if (idx == hac_pkg::POS_W'(k))
                begin
                    scan_next.prefix[k] = hac_pkg::to_lower(in_char_reg);
                end
            end

            if (in_char_reg >= hac_pkg::CH_ZERO && in_char_reg <= hac_pkg::CH_NINE)
            begin
                if (scan_reg.digits == 2'd3)
                begin
                    scan_next.v4_fail = 1'b1;
                end
                else
                begin
                    scan_next.oct_val = tenfold + {6'b0, in_char_reg[3:0]};
                    scan_next.digits  = scan_reg.digits + 2'd1;
                end
            end
            else if (in_char_reg == hac_pkg::CH_DOT)
            begin
                if (scan_reg.digits == 2'd0 || scan_reg.oct_val > 10'd255 ||
                    scan_reg.oct_idx == 2'd3)
                begin
                    scan_next.v4_fail = 1'b1;
                end
                else
                begin
                    if (scan_reg.oct_idx == 2'd0)
                    begin
                        scan_next.first = scan_reg.oct_val[7:0];
                    end
                    if (scan_reg.oct_idx == 2'd1)
                    begin
                        scan_next.second = scan_reg.oct_val[7:0];
                    end
                    if (scan_reg.oct_val != '0)
                    begin
                        scan_next.nonzero = 1'b1;
                    end
                    scan_next.oct_idx = scan_reg.oct_idx + 2'd1;
                    scan_next.oct_val = '0;
                    scan_next.digits  = '0;
                end
            end
            else
            begin
                scan_next.v4_fail = 1'b1;
            end
        end

        if (!overlong)
        begin
            scan_next.pos = scan_reg.pos + hac_pkg::POS_W'(1);
        end
    end

    assign n        = {1'b0, scan_reg.pos} + hac_pkg::LEN_W'(1);
    assign clen     = scan_next.bracket ?
                      ((n >= hac_pkg::LEN_W'(2)) ? n - hac_pkg::LEN_W'(2) : '0) : n;
    assign strip_ok = !scan_next.bracket || closing;
    assign parse_ok = !scan_next.v4_fail && scan_next.oct_idx == 2'd3 &&
                      scan_next.digits != 2'd0 && scan_next.oct_val <= 10'd255;
    assign v4_strip = strip_ok && parse_ok;
    assign v4_plain = !scan_next.bracket && parse_ok;
    assign zero_addr = !scan_next.nonzero && scan_next.oct_val == '0;

    always_comb
    begin
        names_hit = 1'b0;
        for (int b = 0; b < hac_pkg::NAME_COUNT; b++)
        begin
            if (scan_next.names[b] &&
                clen == hac_pkg::LEN_W'(hac_pkg::name_len(hac_pkg::name_id_t'(b))))
            begin
                names_hit = 1'b1;
            end
        end
    end

    assign loop  = strip_ok && (names_hit ||
                   (v4_strip && (scan_next.first == 8'd127 || zero_addr)));
    assign priv4 = v4_plain && (scan_next.first == 8'd10 ||
                   (scan_next.first == 8'd172 && scan_next.second >= 8'd16 &&
                    scan_next.second <= 8'd31) ||
                   (scan_next.first == 8'd192 && scan_next.second == 8'd168));
    assign link  = v4_plain ?
                   (scan_next.first == 8'd169 && scan_next.second == 8'd254) :
                   (strip_ok && clen >= hac_pkg::LEN_W'(4) &&
                    scan_next.prefix[0] == hac_pkg::CH_F &&
                    scan_next.prefix[1] == hac_pkg::CH_E &&
                    (scan_next.prefix[2] == hac_pkg::CH_EIGHT ||
                     scan_next.prefix[2] == hac_pkg::CH_NINE ||
                     scan_next.prefix[2] == hac_pkg::CH_A ||
                     scan_next.prefix[2] == hac_pkg::CH_B));
    assign priv6 = strip_ok && clen >= hac_pkg::LEN_W'(2) &&
                   scan_next.prefix[0] == hac_pkg::CH_F &&
                   (scan_next.prefix[1] == hac_pkg::CH_C ||
                    scan_next.prefix[1] == hac_pkg::CH_D);
    assign is_ip  = scan_next.bracket || scan_next.colons[1] || v4_plain;
    assign labels = {1'b0, scan_next.dots} + hac_pkg::LABEL_W'(1);

    always_comb
    begin
        res_next               = '0;
        res_next.verdict       = hac_pkg::VERD_PASS;
        res_next.warning       = hac_pkg::WARN_NONE;
        res_next.is_ip         = is_ip;
        res_next.is_loopback   = loop;
        res_next.is_private_v4 = priv4;
        res_next.is_link_local = link;
        res_next.is_private_v6 = priv6;
        res_next.label_count   = labels;

        if (loop)
        begin
            if (!allow_localhost_reg)
                res_next.verdict = hac_pkg::VERD_LOOPBACK;
            else
                res_next.warning = hac_pkg::WARN_LOOPBACK;
        end
        if (res_next.verdict == hac_pkg::VERD_PASS && priv4)
        begin
            if (!allow_private_reg)
                res_next.verdict = hac_pkg::VERD_PRIVATE_V4;
            else if (res_next.warning == hac_pkg::WARN_NONE)
                res_next.warning = hac_pkg::WARN_PRIVATE;
        end
        if (res_next.verdict == hac_pkg::VERD_PASS && link)
        begin
            if (!allow_private_reg)
                res_next.verdict = hac_pkg::VERD_LINK_LOCAL;
            else if (res_next.warning == hac_pkg::WARN_NONE)
                res_next.warning = hac_pkg::WARN_LINK_LOCAL;
        end
        if (res_next.verdict == hac_pkg::VERD_PASS && priv6)
        begin
            if (!allow_private_reg)
                res_next.verdict = hac_pkg::VERD_PRIVATE_V6;
            else if (res_next.warning == hac_pkg::WARN_NONE)
                res_next.warning = hac_pkg::WARN_PRIVATE_V6;
        end
        if (res_next.verdict == hac_pkg::VERD_PASS && is_ip && !loop && !priv4 &&
            !link && !priv6)
        begin
            if (!allow_ip_reg)
                res_next.verdict = hac_pkg::VERD_IP_BLOCKED;
            else if (res_next.warning == hac_pkg::WARN_NONE)
                res_next.warning = hac_pkg::WARN_LITERAL_IP;
        end
        if (res_next.verdict == hac_pkg::VERD_PASS && labels > max_depth_reg &&
            res_next.warning == hac_pkg::WARN_NONE)
        begin
            res_next.warning = hac_pkg::WARN_DEEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= hac_pkg::SCAN_RESET;
        end
        else if (advance)
        begin
            scan_reg <= in_last_reg ? hac_pkg::SCAN_RESET : scan_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.verdict       = res_reg.verdict;
    assign result.warning       = res_reg.warning;
    assign result.is_ip         = res_reg.is_ip;
    assign result.is_loopback   = res_reg.is_loopback;
    assign result.is_private_v4 = res_reg.is_private_v4;
    assign result.is_link_local = res_reg.is_link_local;
    assign result.is_private_v6 = res_reg.is_private_v6;
    assign result.label_count   = res_reg.label_count;

endmodule

// ===== hdl/hac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hac_checker
// Port-level assertions on the host address classifier, bound to its top.
// ----------------------------------------------------------------------------
`include "host_address_classifier_macros.svh"

module hac_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [2:0]                    out_verdict,
    input logic [2:0]                    out_warning,
    input logic [hac_pkg::LABEL_W-1:0]   out_label_count
);

    // A pending result stays offered until it is taken.
    `HAC_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid)

    // A new result follows the acceptance of a last byte, with the input register between them.
    `HAC_ASSERT_IMPL(a_result_from_last, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_last, 2))

    // The deep-label warning is only given to hosts that pass.
    `HAC_ASSERT_IMPL(a_deep_only_on_pass, clk, rst_n, out_valid && (out_verdict != hac_pkg::VERD_PASS), out_warning != hac_pkg::WARN_DEEP)

    // Every host has at least one label.
    `HAC_ASSERT_IMPL(a_label_count_nonzero, clk, rst_n, out_valid, out_label_count != '0)

endmodule

bind host_address_classifier hac_checker u_hac_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (host.valid),
    .in_ready        (host.ready),
    .in_last         (host.last),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_verdict     (result.verdict),
    .out_warning     (result.warning),
    .out_label_count (result.label_count)
);

// ===== verif/host_address_classifier_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_address_classifier_test
// Self-checking bench for the host address classifier. Host names are sent
// one byte per transaction. A scoreboard predicts the classification of each
// host and checks every result transaction against it. A directed set of
// hosts runs first, followed by random IPv4, IPv6, domain and noise hosts
// under several register settings. Both channels stall at random.
// ----------------------------------------------------------------------------
module host_address_classifier_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 22;

    class host_verdict_board;
        bit                 allow_loopback;
        bit                 allow_private;
        bit                 allow_literal;
        int unsigned        label_limit;
        int unsigned        pos;
        int unsigned        oct_idx;
        int unsigned        oct_val;
        int unsigned        digits;
        int unsigned        dots;
        int unsigned        first_o;
        int unsigned        second_o;
        bit                 bracket;
        bit                 v4_fail;
        bit                 nonzero;
        bit                 colon_prev;
        bit                 colon_pair;
        bit [3:0]           name_ok;
        byte unsigned       pfx[3];
        string              fixed_name[4];
        hac_pkg::result_t   expected_verdicts[$];
        int                 mismatches;

        function new();
            fixed_name[0]  = "localhost";
            fixed_name[1]  = "localhost.localdomain";
            fixed_name[2]  = "::1";
            fixed_name[3]  = "0:0:0:0:0:0:0:1";
            allow_loopback = 0;
            allow_private  = 0;
            allow_literal  = 0;
            label_limit    = 5;
            mismatches     = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            pos        = 0;
            oct_idx    = 0;
            oct_val    = 0;
            digits     = 0;
            dots       = 0;
            first_o    = 0;
            second_o   = 0;
            bracket    = 0;
            v4_fail    = 0;
            nonzero    = 0;
            colon_prev = 0;
            colon_pair = 0;
            name_ok    = '1;
            pfx[0]     = 0;
            pfx[1]     = 0;
            pfx[2]     = 0;
        endfunction

        function void set_reg(hac_pkg::cfg_reg_t idx, logic [8:0] val);
            case (idx)
                hac_pkg::CFG_ALLOW_LOCALHOST:    allow_loopback = val[0];
                hac_pkg::CFG_ALLOW_PRIVATE_IPS:  allow_private  = val[0];
                hac_pkg::CFG_ALLOW_IP_ADDRESSES: allow_literal  = val[0];
                hac_pkg::CFG_MAX_LABEL_DEPTH:    label_limit    = val;
            endcase
        endfunction

        // One byte of the host with any enclosing bracket removed.
        function void feed(byte unsigned c, int unsigned idx, bit overlong);
            for (int b = 0; b < 4; b++)
            begin
                if (idx >= fixed_name[b].len())
                    name_ok[b] = 0;
                else if (fixed_name[b][idx] != c)
                    name_ok[b] = 0;
            end
            if (overlong)
            begin
                name_ok = 0;
                v4_fail = 1;
            end
            if (idx < 3)
                pfx[idx] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            if (c >= "0" && c <= "9")
            begin
                if (digits >= 3)
                    v4_fail = 1;
                else
                begin
                    oct_val = oct_val * 10 + (c - "0");
                    digits++;
                end
            end
            else if (c == ".")
            begin
                if (digits == 0 || oct_val > 255 || oct_idx >= 3)
                    v4_fail = 1;
                else
                begin
                    if (oct_idx == 0)
                        first_o = oct_val;
                    if (oct_idx == 1)
                        second_o = oct_val;
                    if (oct_val != 0)
                        nonzero = 1;
                    oct_idx++;
                    oct_val = 0;
                    digits  = 0;
                end
            end
            else
                v4_fail = 1;
        endfunction

        function void take_byte(byte unsigned c, bit fin);
            bit                 overlong;
            bit                 closing;
            bit                 strip_ok;
            bit                 parse_ok;
            bit                 v4_strip;
            bit                 v4_plain;
            bit                 zero_addr;
            bit                 names;
            bit                 loop_h;
            bit                 priv4;
            bit                 link;
            bit                 priv6;
            bit                 is_ip;
            int unsigned        n;
            int unsigned        clen;
            int unsigned        labels;
            hac_pkg::verdict_t  v;
            hac_pkg::warning_t  w;
            hac_pkg::result_t   r;

            overlong = (pos >= hac_pkg::MAX_HOST_LEN);
            closing  = 0;
            if (c == "." && dots < 255)
                dots++;
            if (c == ":")
            begin
                if (colon_prev)
                    colon_pair = 1;
                colon_prev = 1;
            end
            else
                colon_prev = 0;

            if (pos == 0 && c == "[")
                bracket = 1;
            else if (fin && bracket && c == "]")
                closing = 1;
            else
                feed(c, pos - bracket, overlong);

            if (!fin)
            begin
                if (pos < hac_pkg::MAX_HOST_LEN)
                    pos++;
                return;
            end

            n         = pos + 1;
            strip_ok  = !bracket || closing;
            clen      = bracket ? ((n >= 2) ? n - 2 : 0) : n;
            parse_ok  = !v4_fail && oct_idx == 3 && digits != 0 && oct_val <= 255;
            v4_strip  = strip_ok && parse_ok;
            v4_plain  = !bracket && parse_ok;
            zero_addr = !nonzero && oct_val == 0;
            names     = 0;
            if (strip_ok)
                for (int b = 0; b < 4; b++)
                    if (name_ok[b] && clen == fixed_name[b].len())
                        names = 1;
            loop_h = strip_ok && (names || (v4_strip && (first_o == 127 || zero_addr)));
            priv4  = v4_plain && (first_o == 10 ||
                     (first_o == 172 && second_o >= 16 && second_o <= 31) ||
                     (first_o == 192 && second_o == 168));
            if (v4_plain)
                link = first_o == 169 && second_o == 254;
            else
                link = strip_ok && clen >= 4 && pfx[0] == "f" && pfx[1] == "e" &&
                       (pfx[2] == "8" || pfx[2] == "9" || pfx[2] == "a" || pfx[2] == "b");
            priv6  = strip_ok && clen >= 2 && pfx[0] == "f" && (pfx[1] == "c" || pfx[1] == "d");
            is_ip  = bracket || colon_pair || v4_plain;
            labels = dots + 1;

            v = hac_pkg::VERD_PASS;
            w = hac_pkg::WARN_NONE;
            if (loop_h)
            begin
                if (!allow_loopback)
                    v = hac_pkg::VERD_LOOPBACK;
                else if (w == hac_pkg::WARN_NONE)
                    w = hac_pkg::WARN_LOOPBACK;
            end
            if (v == hac_pkg::VERD_PASS && priv4)
            begin
                if (!allow_private)
                    v = hac_pkg::VERD_PRIVATE_V4;
                else if (w == hac_pkg::WARN_NONE)
                    w = hac_pkg::WARN_PRIVATE;
            end
            if (v == hac_pkg::VERD_PASS && link)
            begin
                if (!allow_private)
                    v = hac_pkg::VERD_LINK_LOCAL;
                else if (w == hac_pkg::WARN_NONE)
                    w = hac_pkg::WARN_LINK_LOCAL;
            end
            if (v == hac_pkg::VERD_PASS && priv6)
            begin
                if (!allow_private)
                    v = hac_pkg::VERD_PRIVATE_V6;
                else if (w == hac_pkg::WARN_NONE)
                    w = hac_pkg::WARN_PRIVATE_V6;
            end
            if (v == hac_pkg::VERD_PASS && is_ip && !loop_h && !priv4 && !link && !priv6)
            begin
                if (!allow_literal)
                    v = hac_pkg::VERD_IP_BLOCKED;
                else if (w == hac_pkg::WARN_NONE)
                    w = hac_pkg::WARN_LITERAL_IP;
            end
            if (v == hac_pkg::VERD_PASS && labels > label_limit && w == hac_pkg::WARN_NONE)
                w = hac_pkg::WARN_DEEP;

            r.verdict       = v;
            r.warning       = w;
            r.is_ip         = is_ip;
            r.is_loopback   = loop_h;
            r.is_private_v4 = priv4;
            r.is_link_local = link;
            r.is_private_v6 = priv6;
            r.label_count   = 9'(labels);
            expected_verdicts.push_back(r);
            clear_scan();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        task compare_field(string name, logic [8:0] got, logic [8:0] want);
            if (got !== want)
                report($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_verdict(hac_pkg::result_t got);
            hac_pkg::result_t want;
            if (expected_verdicts.size() == 0)
            begin
                report("result transaction with no host outstanding");
                return;
            end
            want = expected_verdicts.pop_front();
            compare_field("verdict", got.verdict, want.verdict);
            compare_field("warning", got.warning, want.warning);
            compare_field("is_ip", got.is_ip, want.is_ip);
            compare_field("is_loopback", got.is_loopback, want.is_loopback);
            compare_field("is_private_v4", got.is_private_v4, want.is_private_v4);
            compare_field("is_link_local", got.is_link_local, want.is_link_local);
            compare_field("is_private_v6", got.is_private_v6, want.is_private_v6);
            compare_field("label_count", got.label_count, want.label_count);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   quiet_cycles;

    host_verdict_board sb;

    hac_host_if   host_ch ();
    hac_result_if res_ch ();
    hac_cfg_if    cfg_ch ();

    host_address_classifier DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .host   (host_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 19);

    always @(posedge clk)
    begin
        hac_pkg::result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.verdict       = hac_pkg::verdict_t'(res_ch.verdict);
            got.warning       = hac_pkg::warning_t'(res_ch.warning);
            got.is_ip         = res_ch.is_ip;
            got.is_loopback   = res_ch.is_loopback;
            got.is_private_v4 = res_ch.is_private_v4;
            got.is_link_local = res_ch.is_link_local;
            got.is_private_v6 = res_ch.is_private_v6;
            got.label_count   = res_ch.label_count;
            sb.check_verdict(got);
        end
    end

    always @(posedge clk)
    begin
        if ((host_ch.valid && host_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void put_text(ref byte unsigned h[$], input string s);
        for (int i = 0; i < s.len(); i++)
            h.push_back(s[i]);
    endfunction

    function automatic void put_number(ref byte unsigned h[$], input int unsigned val);
        string s;
        s = $sformatf("%0d", val);
        if (s.len() < 3 && $urandom_range(0, 5) == 0)
            s = {"0", s};
        else if (s.len() == 3 && $urandom_range(0, 15) == 0)
            s = {"0", s};
        put_text(h, s);
    endfunction

    function automatic int unsigned lead_octet();
        case ($urandom_range(0, 8))
            0:       return 0;
            1:       return 10;
            2:       return 127;
            3:       return 172;
            4:       return 192;
            5:       return 169;
            6:       return 255;
            7:       return $urandom_range(0, 255);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    function automatic int unsigned next_octet();
        case ($urandom_range(0, 8))
            0:       return 0;
            1:       return 16;
            2:       return 31;
            3:       return 15;
            4:       return 32;
            5:       return 168;
            6:       return 254;
            7:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic void make_host(ref byte unsigned h[$]);
        string hex_set;
        string name_set;
        string v6_heads[10];
        string fixed_like[6];
        int    kind;
        int    count;
        bit    bracketed;
        bit    unclosed;

        hex_set    = "0123456789abcdefABCDEF";
        name_set   = "abcdefghijklmnopqrstuvwxyzABCDEFXYZ-0123456789";
        v6_heads   = '{"fe80", "FE9b", "fea0", "feb1", "fec0", "fc00", "FD12", "::1",
                       "0:0:0:0:0:0:0:1", "2001:db8"};
        fixed_like = '{"localhost", "localhost.localdomain", "LocalHost", "localhost.",
                       "localhos", "localhost.localdomain.x"};
        h.delete();
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            bracketed = ($urandom_range(0, 9) == 0);
            if (bracketed)
                put_text(h, "[");
            put_number(h, lead_octet());
            put_text(h, ".");
            put_number(h, next_octet());
            put_text(h, ".");
            put_number(h, next_octet());
            put_text(h, ".");
            put_number(h, next_octet());
            if (bracketed)
                put_text(h, "]");
        end
        else if (kind < 55)
        begin
            bracketed = ($urandom_range(0, 99) < 70);
            unclosed  = ($urandom_range(0, 99) < 15);
            if (bracketed)
                put_text(h, "[");
            put_text(h, v6_heads[$urandom_range(0, 9)]);
            if ($urandom_range(0, 99) < 60)
            begin
                put_text(h, "::");
                count = $urandom_range(1, 3);
                for (int g = 0; g < count; g++)
                begin
                    if (g != 0)
                        put_text(h, ":");
                    repeat ($urandom_range(1, 4))
                        h.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
                end
            end
            if (bracketed && !unclosed)
                put_text(h, "]");
        end
        else if (kind < 75)
        begin
            if ($urandom_range(0, 99) < 30)
                put_text(h, fixed_like[$urandom_range(0, 5)]);
            else
            begin
                case ($urandom_range(0, 9))
                    0: put_text(h, "fe9");
                    1: put_text(h, "fd");
                    2: put_text(h, "FC");
                    default: ;
                endcase
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                    : $urandom_range(1, 6);
                for (int l = 0; l < count; l++)
                begin
                    if (l != 0)
                        put_text(h, ".");
                    repeat ($urandom_range(1, 6))
                        h.push_back(name_set[$urandom_range(0, name_set.len() - 1)]);
                end
            end
        end
        else if (kind < 85)
        begin
            count = $urandom_range(1, 5);
            for (int o = 0; o < count; o++)
            begin
                if (o != 0)
                    put_text(h, ".");
                if ($urandom_range(0, 5) != 0)
                    put_number(h, $urandom_range(0, 999));
            end
            if ($urandom_range(0, 3) == 0)
                put_text(h, ".");
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
                put_text(h, "[");
            repeat ($urandom_range(1, 10))
                h.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) == 0)
                put_text(h, "]");
        end
    endfunction

    task send_byte(byte unsigned c, bit fin);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            host_ch.valid <= 1'b0;
            @(negedge clk);
        end
        host_ch.valid     <= 1'b1;
        host_ch.host_char <= c;
        host_ch.last      <= fin;
        @(posedge clk);
        while (!host_ch.ready)
            @(posedge clk);
        sb.take_byte(c, fin);
        @(negedge clk);
    endtask

    task send_host(byte unsigned h[$]);
        for (int i = 0; i < h.size(); i++)
            send_byte(h[i], i == h.size() - 1);
    endtask

    task wait_for_results();
        host_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_verdicts.size() != 0);
    endtask

    task write_reg(hac_pkg::cfg_reg_t idx, logic [8:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task apply_setting(bit lh, bit pi, bit ia, int unsigned depth);
        wait_for_results();
        repeat (4) @(negedge clk);
        write_reg(hac_pkg::CFG_ALLOW_LOCALHOST, {8'($urandom_range(0, 255)), lh});
        write_reg(hac_pkg::CFG_ALLOW_PRIVATE_IPS, {8'($urandom_range(0, 255)), pi});
        write_reg(hac_pkg::CFG_ALLOW_IP_ADDRESSES, {8'($urandom_range(0, 255)), ia});
        write_reg(hac_pkg::CFG_MAX_LABEL_DEPTH, 9'(depth));
        cfg_ch.valid <= 1'b0;
    endtask

    task run_directed();
        string        hosts[$];
        byte unsigned h[$];
        hosts = '{"localhost", "localhost.localdomain", "::1", "[::1]", "0:0:0:0:0:0:0:1",
                  "127.0.0.1", "0.0.0.0", "000.00.0.0", "10.1.2.3", "172.16.0.1",
                  "172.31.255.255", "172.32.0.1", "192.168.1.1", "169.254.9.9",
                  "255.255.255.255", "256.1.1.1", "1.2.3.0004", "8.8.8.8", "[FE80::1]",
                  "fe8", "fc", "FD00::", "[::1", "[]", "[", "a.b.c.d.e.f.g", "Localhost"};
        foreach (hosts[i])
        begin
            h.delete();
            put_text(h, hosts[i]);
            send_host(h);
        end
        // A host longer than the scan window, with the dot count saturating.
        h.delete();
        put_text(h, "fe80");
        repeat (256) h.push_back(".");
        calm = 1'b1;
        send_host(h);
        calm = 1'b0;
    endtask

    task run_random(bit lh, bit pi, bit ia, int unsigned depth, bit quiet_phase);
        byte unsigned h[$];
        int           sent;
        apply_setting(lh, pi, ia, depth);
        calm = quiet_phase;
        sent = 0;
        while (sent < PHASE_BYTES)
        begin
            make_host(h);
            send_host(h);
            sent += h.size();
            if ($urandom_range(0, 14) == 0)
                wait_for_results();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        sb                = new();
        calm              = 1'b0;
        quiet_cycles      = 0;
        rst_n             = 1'b0;
        host_ch.valid     = 1'b0;
        host_ch.host_char = '0;
        host_ch.last      = 1'b0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = hac_pkg::CFG_ALLOW_LOCALHOST;
        cfg_ch.data       = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        run_random(1'b0, 1'b0, 1'b0, 0, 1'b0);
        run_random(1'b1, 1'b1, 1'b1, 256, 1'b1);
        run_random(1'b1, 1'b0, 1'b1, 5, 1'b0);
        run_random(1'b0, 1'b1, 1'b0, 1, 1'b0);
        run_random($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 256), 1'b0);
        run_random($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 8), 1'b0);

        wait_for_results();
        repeat (8) @(negedge clk);
        if (sb.expected_verdicts.size() != 0)
            sb.report("expected results still outstanding at the end of the run");
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
